>>> hdl/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants of the one-wire bus master: command codes,
// register indexes, timing register reset values, request and result records.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int unsigned REG_BITS = 10;

  localparam logic [2:0] FN_TICK       = 3'd0;
  localparam logic [2:0] FN_RESET      = 3'd1;
  localparam logic [2:0] FN_WRITE_BYTE = 3'd2;
  localparam logic [2:0] FN_READ_BYTE  = 3'd3;
  localparam logic [2:0] FN_WRITE_BIT  = 3'd4;
  localparam logic [2:0] FN_READ_BIT   = 3'd5;

  typedef enum logic [2:0] {
    REG_SLOT_START_LOW     = 3'd0,
    REG_WRITE_ONE_RELEASE  = 3'd1,
    REG_WRITE_ZERO_LOW     = 3'd2,
    REG_WRITE_ZERO_RELEASE = 3'd3,
    REG_READ_SAMPLE_WAIT   = 3'd4,
    REG_READ_RECOVERY      = 3'd5,
    REG_RESET_LOW          = 3'd6,
    REG_PRESENCE_WAIT      = 3'd7
  } reg_idx_t;

  localparam logic [REG_BITS-1:0] RST_SLOT_START_LOW     = 10'd1;
  localparam logic [REG_BITS-1:0] RST_WRITE_ONE_RELEASE  = 10'd64;
  localparam logic [REG_BITS-1:0] RST_WRITE_ZERO_LOW     = 10'd60;
  localparam logic [REG_BITS-1:0] RST_WRITE_ZERO_RELEASE = 10'd10;
  localparam logic [REG_BITS-1:0] RST_READ_SAMPLE_WAIT   = 10'd5;
  localparam logic [REG_BITS-1:0] RST_READ_RECOVERY      = 10'd55;
  localparam logic [REG_BITS-1:0] RST_RESET_LOW          = 10'd480;
  localparam logic [REG_BITS-1:0] RST_PRESENCE_WAIT      = 10'd70;

  localparam logic [REG_BITS-1:0] RESET_RECOVERY = 10'd410;

  typedef struct packed {
    logic [REG_BITS-1:0] slot_start_low;
    logic [REG_BITS-1:0] write_one_release;
    logic [REG_BITS-1:0] write_zero_low;
    logic [REG_BITS-1:0] write_zero_release;
    logic [REG_BITS-1:0] read_sample_wait;
    logic [REG_BITS-1:0] read_recovery;
    logic [REG_BITS-1:0] reset_low;
    logic [REG_BITS-1:0] presence_wait;
  } timing_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
    logic       line_level;
  } request_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } result_t;

endpackage

>>> hdl/owm_cfg.sv
// ----------------------------------------------------------------------------
// owm_cfg
// Timing register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module owm_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  owm_pkg::reg_idx_t             cfg_index,
  input  logic [owm_pkg::REG_BITS-1:0]  cfg_data,
  output owm_pkg::timing_t              tim
);
  import owm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      tim.slot_start_low     <= RST_SLOT_START_LOW;
      tim.write_one_release  <= RST_WRITE_ONE_RELEASE;
      tim.write_zero_low     <= RST_WRITE_ZERO_LOW;
      tim.write_zero_release <= RST_WRITE_ZERO_RELEASE;
      tim.read_sample_wait   <= RST_READ_SAMPLE_WAIT;
      tim.read_recovery      <= RST_READ_RECOVERY;
      tim.reset_low          <= RST_RESET_LOW;
      tim.presence_wait      <= RST_PRESENCE_WAIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOT_START_LOW:     tim.slot_start_low     <= cfg_data;
        REG_WRITE_ONE_RELEASE:  tim.write_one_release  <= cfg_data;
        REG_WRITE_ZERO_LOW:     tim.write_zero_low     <= cfg_data;
        REG_WRITE_ZERO_RELEASE: tim.write_zero_release <= cfg_data;
        REG_READ_SAMPLE_WAIT:   tim.read_sample_wait   <= cfg_data;
        REG_READ_RECOVERY:      tim.read_recovery      <= cfg_data;
        REG_RESET_LOW:          tim.reset_low          <= cfg_data;
        REG_PRESENCE_WAIT:      tim.presence_wait      <= cfg_data;
      endcase
    end
  end

endmodule

>>> hdl/owm_engine.sv
// ----------------------------------------------------------------------------
// owm_engine
// Input register, slot sequencer state and the single-pass next-state logic
// that turns one request into one result.
// ----------------------------------------------------------------------------
module owm_engine #(
  parameter int unsigned TIMER_BITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  owm_pkg::timing_t  tim,
  input  logic              in_valid,
  input  owm_pkg::request_t in_req,
  output logic              in_ready,
  input  logic              res_ready,
  output logic              res_valid,
  output owm_pkg::result_t  res
);
  import owm_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LOW,
    PH_REL,
    PH_SAMPLE,
    PH_RECOV
  } phase_t;

  logic                  req_v;
  request_t              req;
  logic                  fire;

  phase_t                phase, phase_next;
  logic [2:0]            op_kind, op_kind_next;
  logic [TIMER_BITS-1:0] tmr, tmr_next;
  logic [3:0]            bits_left, bits_left_next;
  logic [7:0]            shift_reg, shift_reg_next;
  logic                  presence_flag, presence_flag_next;
  logic [7:0]            last_read, last_read_next;
  logic                  done, rej;

  logic [TIMER_BITS-1:0] a_len, b_len, c_len, d_len, e_len, f_len, h_len, i_len;
  logic [TIMER_BITS-1:0] recov_const, one_tick, tmr_dec;
  logic                  z1, z0;

  logic                  is_cmd, wr, rst_op;
  logic [2:0]            op_eff;
  logic [TIMER_BITS-1:0] rd_low, rd_rel, recov, rel_w;
  phase_t                rd_ph;
  logic [TIMER_BITS-1:0] rd_tmr;
  logic [7:0]            sh_s;

  logic [7:0]            seek_sh, sk_sh;
  logic [3:0]            seek_bl, sk_bl, k;
  logic                  stop;
  logic [TIMER_BITS-1:0] sk_low, sk_rel, sk_tmr;
  phase_t                sk_ph;
  logic                  sk_done;

  logic [3:0]            rf_bl;
  logic                  rf_done;
  phase_t                rf_ph;
  logic [TIMER_BITS-1:0] rf_tmr;

  assign fire      = req_v && res_ready;
  assign in_ready  = !req_v || res_ready;
  assign res_valid = req_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_v <= 1'b0;
    end else if (in_ready) begin
      req_v <= in_valid;
    end
    if (in_ready) begin
      req <= in_req;
    end
  end

  assign a_len       = TIMER_BITS'(tim.slot_start_low);
  assign b_len       = TIMER_BITS'(tim.write_one_release);
  assign c_len       = TIMER_BITS'(tim.write_zero_low);
  assign d_len       = TIMER_BITS'(tim.write_zero_release);
  assign e_len       = TIMER_BITS'(tim.read_sample_wait);
  assign f_len       = TIMER_BITS'(tim.read_recovery);
  assign h_len       = TIMER_BITS'(tim.reset_low);
  assign i_len       = TIMER_BITS'(tim.presence_wait);
  assign recov_const = TIMER_BITS'(RESET_RECOVERY);
  assign one_tick    = TIMER_BITS'(1);
  assign z1          = (a_len == '0) && (b_len == '0);
  assign z0          = (c_len == '0) && (d_len == '0);

  always_comb begin
    is_cmd = (req.func >= FN_RESET) && (req.func <= FN_READ_BIT);
    op_eff = is_cmd ? req.func : op_kind;
    wr     = (op_eff == FN_WRITE_BYTE) || (op_eff == FN_WRITE_BIT);
    rst_op = (op_eff == FN_RESET);
    rd_low = rst_op ? h_len : a_len;
    rd_rel = rst_op ? i_len : e_len;
    recov  = rst_op ? recov_const : f_len;
    rel_w  = shift_reg[0] ? b_len : d_len;
    sh_s   = (phase == PH_SAMPLE && !rst_op) ? {req.line_level, shift_reg[7:1]}
                                             : shift_reg;
    if (rd_low != '0) begin
      rd_ph  = PH_LOW;
      rd_tmr = rd_low;
    end else if (rd_rel != '0) begin
      rd_ph  = PH_REL;
      rd_tmr = rd_rel;
    end else begin
      rd_ph  = PH_SAMPLE;
      rd_tmr = one_tick;
    end
  end

  // skip write bits whose low and release lengths are both zero
  always_comb begin
    if (is_cmd) begin
      seek_sh = (req.func == FN_WRITE_BIT) ? {7'd0, req.data_byte[0]} : req.data_byte;
      seek_bl = (req.func == FN_WRITE_BIT) ? 4'd1 : 4'd8;
    end else begin
      seek_sh = {1'b0, shift_reg[7:1]};
      seek_bl = bits_left - 4'd1;
    end
    k    = 4'd0;
    stop = 1'b0;
    for (int n = 0; n < 8; n++) begin
      if (!stop) begin
        if ((4'(n) < seek_bl) && (seek_sh[n] ? z1 : z0)) begin
          k = k + 4'd1;
        end else begin
          stop = 1'b1;
        end
      end
    end
    sk_sh   = seek_sh >> k;
    sk_bl   = seek_bl - k;
    sk_low  = sk_sh[0] ? a_len : c_len;
    sk_rel  = sk_sh[0] ? b_len : d_len;
    sk_done = (sk_bl == 4'd0);
    if (sk_done) begin
      sk_ph  = PH_IDLE;
      sk_tmr = '0;
    end else if (sk_low != '0) begin
      sk_ph  = PH_LOW;
      sk_tmr = sk_low;
    end else begin
      sk_ph  = PH_REL;
      sk_tmr = sk_rel;
    end
  end

  always_comb begin
    rf_bl   = bits_left - 4'd1;
    rf_done = (rf_bl == 4'd0);
    rf_ph   = rf_done ? PH_IDLE : rd_ph;
    rf_tmr  = rf_done ? '0 : rd_tmr;
  end

  always_comb begin
    phase_next         = phase;
    op_kind_next       = op_kind;
    tmr_next           = tmr;
    bits_left_next     = bits_left;
    shift_reg_next     = shift_reg;
    presence_flag_next = presence_flag;
    last_read_next     = last_read;
    done               = 1'b0;
    rej                = 1'b0;
    tmr_dec            = tmr - one_tick;
    if (is_cmd) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        op_kind_next = req.func;
        if (wr) begin
          phase_next     = sk_ph;
          tmr_next       = sk_tmr;
          shift_reg_next = sk_sh;
          bits_left_next = sk_bl;
          done           = sk_done;
        end else begin
          shift_reg_next = 8'd0;
          bits_left_next = (req.func == FN_READ_BYTE) ? 4'd8 : 4'd1;
          phase_next     = rd_ph;
          tmr_next       = rd_tmr;
        end
      end
    end else if (phase != PH_IDLE) begin
      shift_reg_next = sh_s;
      if (phase == PH_SAMPLE && rst_op) begin
        presence_flag_next = ~req.line_level;
      end
      tmr_next = tmr_dec;
      if (tmr_dec == '0) begin
        case (phase)
          PH_LOW: begin
            if (wr && rel_w != '0) begin
              phase_next = PH_REL;
              tmr_next   = rel_w;
            end else if (wr) begin
              phase_next     = sk_ph;
              tmr_next       = sk_tmr;
              shift_reg_next = sk_sh;
              bits_left_next = sk_bl;
              done           = sk_done;
            end else if (rd_rel != '0) begin
              phase_next = PH_REL;
              tmr_next   = rd_rel;
            end else begin
              phase_next = PH_SAMPLE;
              tmr_next   = one_tick;
            end
          end
          PH_REL: begin
            if (wr) begin
              phase_next     = sk_ph;
              tmr_next       = sk_tmr;
              shift_reg_next = sk_sh;
              bits_left_next = sk_bl;
              done           = sk_done;
            end else begin
              phase_next = PH_SAMPLE;
              tmr_next   = one_tick;
            end
          end
          PH_SAMPLE, PH_RECOV: begin
            if (phase == PH_SAMPLE && recov != '0) begin
              phase_next = PH_RECOV;
              tmr_next   = recov;
            end else begin
              phase_next     = rf_ph;
              tmr_next       = rf_tmr;
              bits_left_next = rf_bl;
              done           = rf_done;
              if (rf_done && !rst_op) begin
                last_read_next = sh_s;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
            tmr_next   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      op_kind       <= FN_TICK;
      tmr           <= '0;
      bits_left     <= 4'd0;
      shift_reg     <= 8'd0;
      presence_flag <= 1'b0;
      last_read     <= 8'd0;
    end else if (fire) begin
      phase         <= phase_next;
      op_kind       <= op_kind_next;
      tmr           <= tmr_next;
      bits_left     <= bits_left_next;
      shift_reg     <= shift_reg_next;
      presence_flag <= presence_flag_next;
      last_read     <= last_read_next;
    end
  end

  always_comb begin
    res.drive_low = (phase_next == PH_LOW);
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = done;
    res.presence  = presence_flag_next;
    res.read_data = last_read_next;
    res.rejected  = rej;
  end

  a_busy_timer: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (tmr != '0))
    else $error("busy sequencer with expired timer");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tmr == '0 && bits_left == 4'd0))
    else $error("idle sequencer holds timer or bit count");

  a_sample_one: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SAMPLE) |-> (tmr == one_tick && op_kind != FN_WRITE_BYTE &&
                              op_kind != FN_WRITE_BIT))
    else $error("sample phase is not a single tick of a read or reset");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && done) |-> (!res.busy_res && !rej))
    else $error("completion reported while still busy");

endmodule

>>> hdl/owm_out_buf.sv
// ----------------------------------------------------------------------------
// owm_out_buf
// Result register between the sequencer and the master-side stream.
// ----------------------------------------------------------------------------
module owm_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  owm_pkg::result_t in_res,
  output logic             in_ready,
  output logic             out_valid,
  output owm_pkg::result_t out_res,
  input  logic             out_ready
);
  import owm_pkg::*;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_res <= in_res;
    end
  end

endmodule

>>> hdl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Standard-speed one-wire bus master: reset with presence detect, byte and
// bit writes and reads, timed by one-microsecond tick requests.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  tick or command request
//   m_*      out        m_tvalid/m_tready  one result per request
//   cfg_*    in         cfg_we             timing register write
//
// One request per cycle sustained while m_tready is high; each request is
// held in the input register, then its result in the result register.
// Reset is synchronous and restores state and timing registers at once.
// A stalled m_tready holds the result and the request behind it; s_tready
// drops once both registers are full.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
  parameter int unsigned TIMER_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,  // data_byte[7:0], line_level[8]
  input  logic [2:0]                    s_tuser,  // func[2:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,  // drive_low, busy_res, done_res,
                                                  // presence, read_data[7:0], rejected
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [owm_pkg::REG_BITS-1:0]  cfg_data
);
  import owm_pkg::*;

  timing_t  tim;
  request_t req;
  result_t  res, out_res;
  logic     res_valid, res_ready;

  assign req.func       = s_tuser;
  assign req.data_byte  = s_tdata[7:0];
  assign req.line_level = s_tdata[8];

  owm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (reg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .tim       (tim)
  );

  owm_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .tim       (tim),
    .in_valid  (s_tvalid),
    .in_req    (req),
    .in_ready  (s_tready),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  owm_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .in_ready  (res_ready),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .out_ready (m_tready)
  );

  assign m_tdata = {3'd0, out_res.rejected, out_res.read_data, out_res.presence,
                    out_res.done_res, out_res.busy_res, out_res.drive_low};

endmodule

>>> tb/tb_one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master
// Self-checking bench for the standard-speed one-wire bus master. A cycle
// model of the slot sequencer follows every accepted request and predicts the
// result record. Directed runs cover the reset timings, small and zero
// timings and the fixed reset recovery. Random runs cover command sequences
// with random bus levels, colliding commands and spare function codes. Both
// stream sides idle at random, and one long receiver stall backs the block up
// into its input.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;
  timeunit 1ns;
  timeprecision 1ps;

  import owm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned ROUND_ITEMS    = 25;
  localparam int unsigned ROUNDS         = 2;

  localparam logic [2:0] FN_SPARE_LO = 3'd6;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_LOW,
    SEQ_RELEASE,
    SEQ_SAMPLE,
    SEQ_RECOVER
  } seq_phase_t;

  typedef enum logic [1:0] {
    LINE_LOW,
    LINE_HIGH,
    LINE_RANDOM
  } line_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata = '0;   // data_byte[7:0], line_level[8]
  logic [2:0]          s_tuser = '0;   // func[2:0]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [15:0]         m_tdata;        // drive_low, busy_res, done_res, presence,
                                       // read_data[7:0], rejected
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [REG_BITS-1:0] cfg_data = '0;

  // sequencer model state
  timing_t             tm;
  seq_phase_t          ph;
  logic [2:0]          op;
  logic [REG_BITS-1:0] timer;
  int unsigned         bits_left;
  logic [7:0]          shreg;
  logic                pres;
  logic [7:0]          last_rd;
  logic                cmd_done;

  result_t     bus_results[$];
  int unsigned requests_sent = 0;
  int unsigned useful_items = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned rejects_seen = 0;
  int unsigned idle_cycles = 0;
  bit          no_gaps = 1'b0;
  int unsigned stall_requests = 0;
  int unsigned stalls_served = 0;
  int unsigned stall_left = 0;

  one_wire_bus_master i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic bit is_command(input logic [2:0] fn);
    return fn >= FN_RESET && fn <= FN_READ_BIT;
  endfunction

  function automatic bit op_reads();
    return op == FN_READ_BYTE || op == FN_READ_BIT;
  endfunction

  function automatic bit op_writes();
    return op == FN_WRITE_BYTE || op == FN_WRITE_BIT;
  endfunction

  function automatic logic [REG_BITS-1:0] slot_low_len();
    if (op == FN_RESET) return tm.reset_low;
    if (op_writes() && !shreg[0]) return tm.write_zero_low;
    return tm.slot_start_low;
  endfunction

  function automatic logic [REG_BITS-1:0] slot_release_len();
    if (op == FN_RESET) return tm.presence_wait;
    if (op_reads()) return tm.read_sample_wait;
    if (shreg[0]) return tm.write_one_release;
    return tm.write_zero_release;
  endfunction

  function automatic void end_of_bit();
    if (bits_left > 0) bits_left--;
    if (op_writes()) shreg = shreg >> 1;
    if (bits_left == 0) begin
      if (op_reads()) last_rd = shreg;
      ph = SEQ_IDLE;
      timer = '0;
      cmd_done = 1'b1;
    end else begin
      ph = SEQ_LOW;
      timer = slot_low_len();
    end
  endfunction

  function automatic void next_segment();
    case (ph)
      SEQ_LOW: begin
        ph = SEQ_RELEASE;
        timer = slot_release_len();
      end
      SEQ_RELEASE: begin
        if (op_reads() || op == FN_RESET) begin
          ph = SEQ_SAMPLE;
          timer = 1;
        end else begin
          end_of_bit();
        end
      end
      SEQ_SAMPLE: begin
        ph = SEQ_RECOVER;
        timer = (op == FN_RESET) ? RESET_RECOVERY : tm.read_recovery;
      end
      SEQ_RECOVER: begin
        end_of_bit();
      end
      default: begin
        ph = SEQ_IDLE;
        timer = '0;
      end
    endcase
  endfunction

  function automatic void skip_empty_segments();
    while (ph != SEQ_IDLE && timer == 0) next_segment();
  endfunction

  function automatic result_t bus_step(input logic [2:0] fn, input logic [7:0] data,
                                       input logic level);
    result_t r;
    logic    rej;
    cmd_done = 1'b0;
    rej = 1'b0;
    if (is_command(fn)) begin
      if (ph != SEQ_IDLE) begin
        rej = 1'b1;
      end else begin
        op = fn;
        case (fn)
          FN_WRITE_BYTE: begin
            shreg = data;
            bits_left = 8;
          end
          FN_WRITE_BIT: begin
            shreg = {7'd0, data[0]};
            bits_left = 1;
          end
          FN_READ_BYTE: begin
            shreg = '0;
            bits_left = 8;
          end
          FN_READ_BIT: begin
            shreg = '0;
            bits_left = 1;
          end
          default: bits_left = 1;
        endcase
        ph = SEQ_LOW;
        timer = slot_low_len();
        skip_empty_segments();
      end
    end else if (ph != SEQ_IDLE) begin
      if (ph == SEQ_SAMPLE) begin
        if (op == FN_RESET) pres = ~level;
        else shreg = {level, shreg[7:1]};
      end
      if (timer > 0) timer--;
      skip_empty_segments();
    end
    r.drive_low = (ph == SEQ_LOW);
    r.busy_res  = (ph != SEQ_IDLE);
    r.done_res  = cmd_done;
    r.presence  = pres;
    r.read_data = last_rd;
    r.rejected  = rej;
    return r;
  endfunction

  // ------------------------------------------------------------- stimulus
  function automatic logic [2:0] tick_code();
    if ($urandom_range(99) < 10) return $urandom_range(1) ? FN_SPARE_HI : FN_SPARE_LO;
    return FN_TICK;
  endfunction

  function automatic logic [2:0] random_transfer();
    case ($urandom_range(3))
      0: return FN_WRITE_BYTE;
      1: return FN_READ_BYTE;
      2: return FN_WRITE_BIT;
      default: return FN_READ_BIT;
    endcase
  endfunction

  function automatic logic [2:0] random_command();
    if ($urandom_range(99) < 8) return FN_RESET;
    return random_transfer();
  endfunction

  function automatic logic line_for(input line_mode_t mode);
    if (mode == LINE_LOW) return 1'b0;
    if (mode == LINE_HIGH) return 1'b1;
    return 1'($urandom_range(1));
  endfunction

  function automatic timing_t random_timing(input int unsigned top);
    timing_t t;
    t.slot_start_low     = REG_BITS'($urandom_range(top));
    t.write_one_release  = REG_BITS'($urandom_range(top));
    t.write_zero_low     = REG_BITS'($urandom_range(top));
    t.write_zero_release = REG_BITS'($urandom_range(top));
    t.read_sample_wait   = REG_BITS'($urandom_range(top));
    t.read_recovery      = REG_BITS'($urandom_range(top));
    t.reset_low          = REG_BITS'($urandom_range(top));
    t.presence_wait      = REG_BITS'($urandom_range(top));
    return t;
  endfunction

  task automatic send_request(input logic [2:0] fn, input logic [7:0] data,
                              input logic level);
    while (!no_gaps && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {7'd0, level, data};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (is_command(fn) || ph != SEQ_IDLE) useful_items++;
    bus_results.push_back(bus_step(fn, data, level));
    requests_sent++;
  endtask

  // issue a command and tick it to completion, optionally colliding once
  task automatic run_command(input logic [2:0] fn, input logic [7:0] data,
                             input line_mode_t mode, input bit collide);
    int countdown;
    countdown = $urandom_range(0, 20);
    send_request(fn, data, 1'($urandom_range(1)));
    while (ph != SEQ_IDLE) begin
      if (collide && countdown == 0)
        send_request(random_command(), 8'($urandom), 1'($urandom_range(1)));
      else
        send_request(tick_code(), 8'($urandom), line_for(mode));
      countdown--;
    end
  endtask

  // finish the running command, drain results and let the pipeline empty
  task automatic wind_down();
    while (ph != SEQ_IDLE) send_request(tick_code(), 8'($urandom), 1'($urandom_range(1)));
    s_tvalid <= 1'b0;
    while (bus_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_timing(input timing_t t);
    logic [REG_BITS-1:0] v;
    for (int i = 0; i < 8; i++) begin
      case (reg_idx_t'(i))
        REG_SLOT_START_LOW:     v = t.slot_start_low;
        REG_WRITE_ONE_RELEASE:  v = t.write_one_release;
        REG_WRITE_ZERO_LOW:     v = t.write_zero_low;
        REG_WRITE_ZERO_RELEASE: v = t.write_zero_release;
        REG_READ_SAMPLE_WAIT:   v = t.read_sample_wait;
        REG_READ_RECOVERY:      v = t.read_recovery;
        REG_RESET_LOW:          v = t.reset_low;
        default:                v = t.presence_wait;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= v;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    tm = t;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_reset_values();
    run_command(FN_WRITE_BIT, 8'h01, LINE_RANDOM, 1'b1);
    run_command(FN_WRITE_BIT, 8'h00, LINE_RANDOM, 1'b0);
    run_command(FN_READ_BIT, 8'h00, LINE_HIGH, 1'b0);
    wind_down();
  endtask

  task automatic test_directed_small();
    program_timing('{slot_start_low: 10'd1, write_one_release: 10'd2,
                     write_zero_low: 10'd3, write_zero_release: 10'd1,
                     read_sample_wait: 10'd2, read_recovery: 10'd1,
                     reset_low: 10'd3, presence_wait: 10'd2});
    send_request(FN_TICK, 8'hFF, 1'b1);
    send_request(FN_SPARE_LO, 8'h00, 1'b0);
    send_request(FN_SPARE_HI, 8'h55, 1'b1);
    run_command(FN_WRITE_BYTE, 8'hA5, LINE_RANDOM, 1'b1);
    run_command(FN_READ_BYTE, 8'h3C, LINE_RANDOM, 1'b1);
    run_command(FN_WRITE_BIT, 8'hFE, LINE_RANDOM, 1'b0);
    run_command(FN_READ_BIT, 8'h00, LINE_LOW, 1'b1);
    wind_down();
  endtask

  task automatic test_zero_timing();
    program_timing('0);
    run_command(FN_WRITE_BYTE, 8'h3C, LINE_RANDOM, 1'b0);
    run_command(FN_WRITE_BIT, 8'h01, LINE_RANDOM, 1'b0);
    run_command(FN_WRITE_BIT, 8'h00, LINE_RANDOM, 1'b0);
    run_command(FN_READ_BIT, 8'h00, LINE_HIGH, 1'b0);
    run_command(FN_READ_BYTE, 8'h00, LINE_RANDOM, 1'b1);
    run_command(FN_RESET, 8'h00, LINE_LOW, 1'b1);
    wind_down();
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    for (int round = 0; round < ROUNDS; round++) begin
      program_timing(random_timing((round == ROUNDS - 1) ? 4 : 2));
      stop_at = useful_items + ROUND_ITEMS;
      while (useful_items < stop_at) begin
        if ($urandom_range(99) < 85)
          run_command(random_transfer(), 8'($urandom), LINE_RANDOM,
                      $urandom_range(99) < 15);
        else
          send_request(($urandom_range(1) != 0) ? random_transfer() : tick_code(),
                       8'($urandom), 1'($urandom_range(1)));
      end
      wind_down();
    end
  endtask

  task automatic test_backpressure();
    int unsigned stop_at;
    program_timing(random_timing(3));
    no_gaps = 1'b1;
    stall_requests++;
    stop_at = useful_items + 30;
    while (useful_items < stop_at)
      run_command(random_transfer(), 8'($urandom), LINE_RANDOM, $urandom_range(99) < 10);
    no_gaps = 1'b0;
    wind_down();
  endtask

  // ------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_served != stall_requests) begin
      stalls_served <= stalls_served + 1;
      stall_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_gaps || ($urandom_range(99) >= 21);
    end
  end

  task automatic compare_field(input string name, input logic [7:0] expected,
                               input logic [7:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expected, actual);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (m_tdata[12]) rejects_seen++;
        if (bus_results.size() == 0) begin
          $display("%0t: result %0h with nothing outstanding", $time, m_tdata);
          mismatches++;
        end else begin
          exp_r = bus_results.pop_front();
          compare_field("drive_low", 8'(exp_r.drive_low), 8'(m_tdata[0]));
          compare_field("busy_res", 8'(exp_r.busy_res), 8'(m_tdata[1]));
          compare_field("done_res", 8'(exp_r.done_res), 8'(m_tdata[2]));
          compare_field("presence", 8'(exp_r.presence), 8'(m_tdata[3]));
          compare_field("read_data", exp_r.read_data, m_tdata[11:4]);
          compare_field("rejected", 8'(exp_r.rejected), 8'(m_tdata[12]));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ----------------------------------------------------------------- main
  initial begin
    tm = '{slot_start_low: RST_SLOT_START_LOW, write_one_release: RST_WRITE_ONE_RELEASE,
           write_zero_low: RST_WRITE_ZERO_LOW, write_zero_release: RST_WRITE_ZERO_RELEASE,
           read_sample_wait: RST_READ_SAMPLE_WAIT, read_recovery: RST_READ_RECOVERY,
           reset_low: RST_RESET_LOW, presence_wait: RST_PRESENCE_WAIT};
    ph = SEQ_IDLE;
    op = FN_TICK;
    timer = '0;
    bits_left = 0;
    shreg = '0;
    pres = 1'b0;
    last_rd = '0;
    cmd_done = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_small();
    test_zero_timing();
    test_random_traffic();
    test_backpressure();
    wind_down();
    $display("Covered %0d requests (%0d while busy or commands), %0d results checked,",
             requests_sent, useful_items, results_seen);
    $display("%0d collisions rejected, timing sets: reset, small, zero, random.",
             rejects_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/owm_pkg.sv
hdl/owm_cfg.sv
hdl/owm_engine.sv
hdl/owm_out_buf.sv
hdl/one_wire_bus_master.sv
tb/tb_one_wire_bus_master.sv
